[src/mbs_pkg.sv]
// ----------------------------------------------------------------------------
// Motion block SAD engine package
// Shared widths, register and kind codes, the configuration and queue entry
// types, and the sub-pel vector split helpers.
// ----------------------------------------------------------------------------
package mbs_pkg;

  // Largest luma block edge supported by the counters and origin math
  localparam int MAX_BLOCK_SIZE = 32;

  localparam int PIX_W      = 8;
  localparam int VEC_W      = 16;
  localparam int IDX_W      = 10;
  localparam int PITCH_W    = 16;
  localparam int IMG_W      = 24;
  localparam int PAD_W      = 8;
  localparam int SRC_OFF_W  = 31;
  localparam int REF_OFF_W  = 32;
  localparam int SAD_W      = 19;
  localparam int PLANE_W    = 4;
  localparam int IMG_PROD_W = IMG_W + PLANE_W;

  localparam int SIZE_W   = $clog2(MAX_BLOCK_SIZE + 1);
  localparam int HALF_W   = SIZE_W - 1;
  localparam int CNT_W    = $clog2(MAX_BLOCK_SIZE * MAX_BLOCK_SIZE
                                   + (MAX_BLOCK_SIZE * MAX_BLOCK_SIZE) / 2 + 1);
  localparam int ORIGIN_W = $clog2(255 + 1023 * (MAX_BLOCK_SIZE / 2) + 1);

  localparam logic [SAD_W-1:0] SAD_MAX = {SAD_W{1'b1}};

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NPEL_MODE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHROMA_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_SIZE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_Y       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_UV      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_PITCH_Y   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_PITCH_UV  = 3'd7;

  // Item and result kinds
  localparam logic KIND_BEGIN     = 1'b0;
  localparam logic KIND_PIXEL     = 1'b1;
  localparam logic RESULT_OFFSETS = 1'b0;
  localparam logic RESULT_SAD     = 1'b1;

  // Sub-pel modes; every other code means quarter pel
  localparam logic [2:0] NPEL_FULL = 3'd1;
  localparam logic [2:0] NPEL_HALF = 3'd2;

  typedef struct packed {
    logic [5:0]         block_size;
    logic [2:0]         npel_mode;
    logic               chroma_enable;
    logic [PAD_W-1:0]   pad_size;
    logic [PITCH_W-1:0] pitch_y;
    logic [PITCH_W-1:0] pitch_uv;
    logic [IMG_W-1:0]   img_pitch_y;
    logic [IMG_W-1:0]   img_pitch_uv;
  } cfg_t;

  // Classified item as it waits between front and back
  typedef struct packed {
    logic                kind;
    logic [ORIGIN_W-1:0] x0;
    logic [ORIGIN_W-1:0] y0;
    logic [VEC_W-1:0]    vec_x;
    logic [VEC_W-1:0]    vec_y;
    logic [PIX_W-1:0]    diff;
  } item_t;

  // Clamp the block edge to 4..MAX_BLOCK_SIZE
  function automatic logic [SIZE_W-1:0] eff_size(input logic [5:0] bs);
    logic [SIZE_W-1:0] s;
    if (bs < 6'd4) begin
      s = SIZE_W'(4);
    end else if (int'(bs) > MAX_BLOCK_SIZE) begin
      s = SIZE_W'(MAX_BLOCK_SIZE);
    end else begin
      s = SIZE_W'(bs);
    end
    return s;
  endfunction

  // Floor of v over the sub-pel step count
  function automatic logic [VEC_W-1:0] sub_quot(input logic [VEC_W-1:0] v,
                                                input logic [2:0] mode);
    logic [VEC_W-1:0] q;
    case (mode)
      NPEL_FULL: q = v;
      NPEL_HALF: q = {v[VEC_W-1], v[VEC_W-1:1]};
      default:   q = {{2{v[VEC_W-1]}}, v[VEC_W-1:2]};
    endcase
    return q;
  endfunction

  // Sub-pel plane index: frac_x + frac_y * steps
  function automatic logic [PLANE_W-1:0] sub_plane(input logic [VEC_W-1:0] vx,
                                                   input logic [VEC_W-1:0] vy,
                                                   input logic [2:0] mode);
    logic [PLANE_W-1:0] p;
    case (mode)
      NPEL_FULL: p = '0;
      NPEL_HALF: p = {2'b00, vy[0], vx[0]};
      default:   p = {vy[1:0], vx[1:0]};
    endcase
    return p;
  endfunction

  // Chroma vector: floor of v over two
  function automatic logic [VEC_W-1:0] chroma_vec(input logic [VEC_W-1:0] v);
    return {v[VEC_W-1], v[VEC_W-1:1]};
  endfunction

endpackage

[src/mbs_if.sv]
// ----------------------------------------------------------------------------
// Motion block SAD engine channels
// Item, result and configuration write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mbs_item_if import mbs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic signed [VEC_W-1:0] vec_x;
  logic signed [VEC_W-1:0] vec_y;
  logic [IDX_W-1:0]        block_col;
  logic [IDX_W-1:0]        block_row;
  logic [PIX_W-1:0]        src_pixel;
  logic [PIX_W-1:0]        ref_pixel;

  modport source (output valid, kind, vec_x, vec_y, block_col, block_row,
                  src_pixel, ref_pixel, input ready);
  modport sink (input valid, kind, vec_x, vec_y, block_col, block_row,
                src_pixel, ref_pixel, output ready);
endinterface

interface mbs_result_if import mbs_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        result_kind;
  logic [SRC_OFF_W-1:0]        src_luma_offset;
  logic signed [REF_OFF_W-1:0] ref_luma_offset;
  logic [SRC_OFF_W-1:0]        src_chroma_offset;
  logic signed [REF_OFF_W-1:0] ref_chroma_offset;
  logic [SAD_W-1:0]            sad;
  logic signed [VEC_W-1:0]     mv_x;
  logic signed [VEC_W-1:0]     mv_y;

  modport source (output valid, result_kind, src_luma_offset, ref_luma_offset,
                  src_chroma_offset, ref_chroma_offset, sad, mv_x, mv_y,
                  input ready);
  modport sink (input valid, result_kind, src_luma_offset, ref_luma_offset,
                src_chroma_offset, ref_chroma_offset, sad, mv_x, mv_y,
                output ready);
endinterface

interface mbs_cfg_if import mbs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/mbs_front.sv]
// ----------------------------------------------------------------------------
// Motion block SAD engine front end
// Accepts items, works out the luma block origin for begin requests and the
// absolute pixel difference for pixel requests, and pushes them to the queue.
// ----------------------------------------------------------------------------
module mbs_front import mbs_pkg::*; (
  input  cfg_t          cfg_regs,
  mbs_item_if.sink      item,
  output logic          push_valid,
  input  logic          push_ready,
  output item_t         push_data
);

  logic [HALF_W-1:0]   half;
  logic [ORIGIN_W-1:0] col_span;
  logic [ORIGIN_W-1:0] row_span;

  // Blocks overlap by half an edge
  assign half     = HALF_W'(eff_size(cfg_regs.block_size) >> 1);
  assign col_span = ORIGIN_W'(item.block_col) * ORIGIN_W'(half);
  assign row_span = ORIGIN_W'(item.block_row) * ORIGIN_W'(half);

  // Classify and pack the request
  always_comb begin
    push_data.kind  = item.kind;
    push_data.x0    = ORIGIN_W'(cfg_regs.pad_size) + col_span;
    push_data.y0    = ORIGIN_W'(cfg_regs.pad_size) + row_span;
    push_data.vec_x = item.vec_x;
    push_data.vec_y = item.vec_y;
    if (item.src_pixel >= item.ref_pixel) begin
      push_data.diff = item.src_pixel - item.ref_pixel;
    end else begin
      push_data.diff = item.ref_pixel - item.src_pixel;
    end
  end

  assign push_valid = item.valid;
  assign item.ready = push_ready;

endmodule

[src/mbs_queue.sv]
// ----------------------------------------------------------------------------
// Motion block SAD engine queue
// Short FIFO of classified requests between front end and back end.
// ----------------------------------------------------------------------------
module mbs_queue import mbs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_data
);

  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t              mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;
  logic               push;
  logic               pop;

  assign push_ready = (count != COUNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/mbs_back.sv]
// ----------------------------------------------------------------------------
// Motion block SAD engine back end
// Updates the sum, pixel count and latched vector, forms the offset products
// in a registered stage, and adds them into the result register.
// ----------------------------------------------------------------------------
module mbs_back import mbs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg_regs,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  item_t      pop_data,
  mbs_result_if.source result
);

  // Block state
  logic [SAD_W-1:0] acc;
  logic [CNT_W-1:0] cnt;
  logic [VEC_W-1:0] lvx;
  logic [VEC_W-1:0] lvy;

  // Product stage
  logic                  s1_valid;
  logic                  s1_kind;
  logic                  s1_chroma;
  logic [ORIGIN_W-1:0]   s1_x0;
  logic [ORIGIN_W-1:0]   s1_cx0;
  logic [SRC_OFF_W-1:0]  s1_src_y_prod;
  logic [SRC_OFF_W-1:0]  s1_src_c_prod;
  logic [REF_OFF_W-1:0]  s1_qx;
  logic [REF_OFF_W-1:0]  s1_ref_y_prod;
  logic [IMG_PROD_W-1:0] s1_img_y_prod;
  logic [REF_OFF_W-1:0]  s1_cqx;
  logic [REF_OFF_W-1:0]  s1_ref_c_prod;
  logic [IMG_PROD_W-1:0] s1_img_c_prod;
  logic [SAD_W-1:0]      s1_sad;
  logic [VEC_W-1:0]      s1_mvx;
  logic [VEC_W-1:0]      s1_mvy;

  // Result register
  logic                 out_valid;
  logic                 out_kind;
  logic [SRC_OFF_W-1:0] out_src_luma;
  logic [REF_OFF_W-1:0] out_ref_luma;
  logic [SRC_OFF_W-1:0] out_src_chroma;
  logic [REF_OFF_W-1:0] out_ref_chroma;
  logic [SAD_W-1:0]     out_sad;
  logic [VEC_W-1:0]     out_mvx;
  logic [VEC_W-1:0]     out_mvy;

  logic adv1;
  logic adv2;
  logic take;

  logic [SIZE_W-1:0]  size;
  logic [HALF_W-1:0]  half;
  logic [CNT_W-1:0]   total;
  logic [CNT_W-1:0]   cnt_inc;
  logic               done;
  logic [SAD_W:0]     sum_wide;
  logic [SAD_W-1:0]   sum_sat;

  logic [VEC_W-1:0]   qx;
  logic [VEC_W-1:0]   qy;
  logic [PLANE_W-1:0] plane_y;
  logic [VEC_W-1:0]   cvx;
  logic [VEC_W-1:0]   cvy;
  logic [VEC_W-1:0]   cqx;
  logic [VEC_W-1:0]   cqy;
  logic [PLANE_W-1:0] plane_c;
  logic [ORIGIN_W-1:0] cy0;

  logic [SRC_OFF_W-1:0]  src_y_prod;
  logic [SRC_OFF_W-1:0]  src_c_prod;
  logic [REF_OFF_W-1:0]  ref_y_prod;
  logic [REF_OFF_W-1:0]  ref_c_prod;
  logic [IMG_PROD_W-1:0] img_y_prod;
  logic [IMG_PROD_W-1:0] img_c_prod;

  // Pipeline flow: stall everything behind a held result
  assign adv2      = s1_valid && (!out_valid || result.ready);
  assign adv1      = !s1_valid || adv2;
  assign pop_ready = adv1;
  assign take      = pop_valid && adv1;

  // Block size, pixel total and saturating sum
  assign size     = eff_size(cfg_regs.block_size);
  assign half     = HALF_W'(size >> 1);
  assign total    = CNT_W'(size) * CNT_W'(size)
                  + (cfg_regs.chroma_enable ?
                     CNT_W'((CNT_W'(half) * CNT_W'(half)) << 1) : '0);
  assign cnt_inc  = cnt + 1'b1;
  assign done     = (cnt_inc >= total);
  assign sum_wide = {1'b0, acc} + (SAD_W + 1)'(pop_data.diff);
  assign sum_sat  = sum_wide[SAD_W] ? SAD_MAX : sum_wide[SAD_W-1:0];

  // Split the vectors into whole-pel steps and sub-pel plane
  assign qx      = sub_quot(pop_data.vec_x, cfg_regs.npel_mode);
  assign qy      = sub_quot(pop_data.vec_y, cfg_regs.npel_mode);
  assign plane_y = sub_plane(pop_data.vec_x, pop_data.vec_y, cfg_regs.npel_mode);
  assign cvx     = chroma_vec(pop_data.vec_x);
  assign cvy     = chroma_vec(pop_data.vec_y);
  assign cqx     = sub_quot(cvx, cfg_regs.npel_mode);
  assign cqy     = sub_quot(cvy, cfg_regs.npel_mode);
  assign plane_c = sub_plane(cvx, cvy, cfg_regs.npel_mode);
  assign cy0     = pop_data.y0 >> 1;

  // Offset products, one multiplier each
  assign src_y_prod = SRC_OFF_W'(pop_data.y0) * SRC_OFF_W'(cfg_regs.pitch_y);
  assign src_c_prod = SRC_OFF_W'(cy0) * SRC_OFF_W'(cfg_regs.pitch_uv);
  assign ref_y_prod = REF_OFF_W'($signed($signed(REF_OFF_W'($signed(qy)))
                    * $signed({{(REF_OFF_W-PITCH_W){1'b0}}, cfg_regs.pitch_y})));
  assign ref_c_prod = REF_OFF_W'($signed($signed(REF_OFF_W'($signed(cqy)))
                    * $signed({{(REF_OFF_W-PITCH_W){1'b0}}, cfg_regs.pitch_uv})));
  assign img_y_prod = IMG_PROD_W'(plane_y) * IMG_PROD_W'(cfg_regs.img_pitch_y);
  assign img_c_prod = IMG_PROD_W'(plane_c) * IMG_PROD_W'(cfg_regs.img_pitch_uv);

  // Update block state on each popped request
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
      lvx <= '0;
      lvy <= '0;
    end else if (take) begin
      case (pop_data.kind)
        KIND_BEGIN: begin
          acc <= '0;
          cnt <= '0;
          lvx <= pop_data.vec_x;
          lvy <= pop_data.vec_y;
        end
        default: begin
          if (done) begin
            acc <= '0;
            cnt <= '0;
          end else begin
            acc <= sum_sat;
            cnt <= cnt_inc;
          end
        end
      endcase
    end
  end

  // Product stage valid: only requests that yield a result go on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= take && ((pop_data.kind == KIND_BEGIN) || done);
    end
  end

  // Product stage payload
  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_kind       <= (pop_data.kind == KIND_BEGIN) ? RESULT_OFFSETS : RESULT_SAD;
      s1_chroma     <= cfg_regs.chroma_enable;
      s1_x0         <= pop_data.x0;
      s1_cx0        <= pop_data.x0 >> 1;
      s1_src_y_prod <= src_y_prod;
      s1_src_c_prod <= src_c_prod;
      s1_qx         <= REF_OFF_W'($signed(qx));
      s1_ref_y_prod <= ref_y_prod;
      s1_img_y_prod <= img_y_prod;
      s1_cqx        <= REF_OFF_W'($signed(cqx));
      s1_ref_c_prod <= ref_c_prod;
      s1_img_c_prod <= img_c_prod;
      s1_sad        <= sum_sat;
      if (pop_data.kind == KIND_BEGIN) begin
        s1_mvx <= pop_data.vec_x;
        s1_mvy <= pop_data.vec_y;
      end else begin
        s1_mvx <= lvx;
        s1_mvy <= lvy;
      end
    end
  end

  // Result register valid: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv2) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Sum the products into the result fields
  always_ff @(posedge clk) begin
    if (adv2) begin
      out_kind <= s1_kind;
      out_mvx  <= s1_mvx;
      out_mvy  <= s1_mvy;
      case (s1_kind)
        RESULT_OFFSETS: begin
          out_sad      <= '0;
          out_src_luma <= SRC_OFF_W'(s1_x0) + s1_src_y_prod;
          out_ref_luma <= s1_qx + s1_ref_y_prod + REF_OFF_W'(s1_img_y_prod);
          if (s1_chroma) begin
            out_src_chroma <= SRC_OFF_W'(s1_cx0) + s1_src_c_prod;
            out_ref_chroma <= s1_cqx + s1_ref_c_prod + REF_OFF_W'(s1_img_c_prod);
          end else begin
            out_src_chroma <= '0;
            out_ref_chroma <= '0;
          end
        end
        default: begin
          out_sad        <= s1_sad;
          out_src_luma   <= '0;
          out_ref_luma   <= '0;
          out_src_chroma <= '0;
          out_ref_chroma <= '0;
        end
      endcase
    end
  end

  assign result.valid             = out_valid;
  assign result.result_kind       = out_kind;
  assign result.src_luma_offset   = out_src_luma;
  assign result.ref_luma_offset   = out_ref_luma;
  assign result.src_chroma_offset = out_src_chroma;
  assign result.ref_chroma_offset = out_ref_chroma;
  assign result.sad               = out_sad;
  assign result.mv_x              = out_mvx;
  assign result.mv_y              = out_mvy;

endmodule

[src/motion_block_sad_engine_unit.sv]
// ----------------------------------------------------------------------------
// Motion block SAD engine
// Block-begin requests return source and reference offsets; pixel requests
// accumulate absolute differences until the block's pixel total is reached.
// Path: a result passes the queue, the product stage and the result register.
// Throughput: one request per cycle while no result is held, set by the sum
// update of the back end; a two-entry queue lets the two stall independently.
// Reset: sum, count and latched vector clear, registers take their defaults.
// ----------------------------------------------------------------------------
module motion_block_sad_engine_unit import mbs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  mbs_item_if.sink     item,
  mbs_result_if.source result,
  mbs_cfg_if.sink      cfg
);

  cfg_t  cfg_regs;
  logic  push_valid;
  logic  push_ready;
  item_t push_data;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_data;

  assign cfg.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.block_size    <= 6'd8;
      cfg_regs.npel_mode     <= NPEL_FULL;
      cfg_regs.chroma_enable <= 1'b0;
      cfg_regs.pad_size      <= '0;
      cfg_regs.pitch_y       <= PITCH_W'(2048);
      cfg_regs.pitch_uv      <= PITCH_W'(1024);
      cfg_regs.img_pitch_y   <= '0;
      cfg_regs.img_pitch_uv  <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_BLOCK_SIZE:    cfg_regs.block_size    <= cfg.data[5:0];
        REG_NPEL_MODE:     cfg_regs.npel_mode     <= cfg.data[2:0];
        REG_CHROMA_ENABLE: cfg_regs.chroma_enable <= cfg.data[0];
        REG_PAD_SIZE:      cfg_regs.pad_size      <= cfg.data[PAD_W-1:0];
        REG_PITCH_Y:       cfg_regs.pitch_y       <= cfg.data[PITCH_W-1:0];
        REG_PITCH_UV:      cfg_regs.pitch_uv      <= cfg.data[PITCH_W-1:0];
        REG_IMG_PITCH_Y:   cfg_regs.img_pitch_y   <= cfg.data[IMG_W-1:0];
        REG_IMG_PITCH_UV:  cfg_regs.img_pitch_uv  <= cfg.data[IMG_W-1:0];
        default: ;
      endcase
    end
  end

  mbs_front u_front (
    .cfg_regs   (cfg_regs),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  mbs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  mbs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_regs  (cfg_regs),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .result    (result)
  );

endmodule

[sim/motion_block_sad_engine_unit_tb.sv]
// ----------------------------------------------------------------------------
// Motion block SAD engine testbench
// Drives block-begin and pixel-pair requests into the engine with random
// idle gaps on the request side and random stalls on the result side. A
// predictor tracks the registers, the latched vector, the pixel count and
// the running sum, queues the expected offsets and SAD results, and every
// result is compared field by field against the oldest queued expectation.
// ----------------------------------------------------------------------------
module motion_block_sad_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mbs_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 9;
  localparam int SETTLE_CYCLES  = 8;
  localparam int IDLE_LIMIT     = 2000;
  localparam int RANDOM_ITEMS   = 320;
  localparam int LONG_BLOCK     = 400;
  localparam int LARGEST_PIXELS = 200;

  localparam logic [CFG_IDX_W-1:0] ALL_REGS [8] = '{
    REG_BLOCK_SIZE, REG_NPEL_MODE, REG_CHROMA_ENABLE, REG_PAD_SIZE,
    REG_PITCH_Y, REG_PITCH_UV, REG_IMG_PITCH_Y, REG_IMG_PITCH_UV
  };

  typedef struct {
    logic                        result_kind;
    logic [SRC_OFF_W-1:0]        src_luma_offset;
    logic signed [REF_OFF_W-1:0] ref_luma_offset;
    logic [SRC_OFF_W-1:0]        src_chroma_offset;
    logic signed [REF_OFF_W-1:0] ref_chroma_offset;
    logic [SAD_W-1:0]            sad;
    logic signed [VEC_W-1:0]     mv_x;
    logic signed [VEC_W-1:0]     mv_y;
  } engine_result_t;

  logic clk = 1'b0;
  logic rst;

  mbs_item_if   item_ch ();
  mbs_result_if result_ch ();
  mbs_cfg_if    cfg_ch ();

  motion_block_sad_engine_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // Predictor state
  cfg_t                    regs_model;
  logic [SAD_W-1:0]        sum_model;
  int unsigned             pixels_model;
  logic signed [VEC_W-1:0] vec_x_model;
  logic signed [VEC_W-1:0] vec_y_model;
  engine_result_t          engine_results_due[$];

  int unsigned mismatches = 0;
  int unsigned requests_sent = 0;
  int unsigned idle_cycles = 0;
  bit          send_idle = 1'b1;
  bit          sink_stalls = 1'b1;

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------- predictor

  // Clamp the luma edge to the supported range
  function automatic int unsigned block_edge();
    int unsigned s;
    s = regs_model.block_size;
    if (s < 4) begin
      s = 4;
    end else if (s > MAX_BLOCK_SIZE) begin
      s = MAX_BLOCK_SIZE;
    end
    return s;
  endfunction

  // Luma pixels plus both chroma planes when enabled
  function automatic int unsigned block_total();
    int unsigned e;
    int unsigned h;
    e = block_edge();
    h = e >> 1;
    return e * e + (regs_model.chroma_enable ? 2 * h * h : 0);
  endfunction

  function automatic int unsigned npel_steps();
    if (regs_model.npel_mode == NPEL_FULL) return 1;
    if (regs_model.npel_mode == NPEL_HALF) return 2;
    return 4;
  endfunction

  // Floor of v over n steps; frac gets v mod n
  function automatic longint floor_steps(input longint v, input int unsigned n,
                                         output int unsigned frac);
    frac = int'(v & longint'(n - 1));
    return (v - longint'(frac)) / longint'(n);
  endfunction

  // Full-pel move plus the sub-pel plane stride, wrapped to 32 bits
  function automatic logic [31:0] displacement_of(input longint vx, input longint vy,
                                                  input longint pitch, input longint img);
    int unsigned n;
    int unsigned fx;
    int unsigned fy;
    longint qx;
    longint qy;
    longint r;
    n = npel_steps();
    qx = floor_steps(vx, n, fx);
    qy = floor_steps(vy, n, fy);
    r = qx + qy * pitch + longint'(fx + fy * n) * img;
    return r[31:0];
  endfunction

  // Begin request: latch the vector, restart the block, queue the offsets
  function automatic void predict_offsets(input logic signed [VEC_W-1:0] vx,
                                          input logic signed [VEC_W-1:0] vy,
                                          input logic [IDX_W-1:0] col,
                                          input logic [IDX_W-1:0] row);
    engine_result_t res;
    longint x0;
    longint y0;
    longint cx;
    longint cy;
    longint t;
    int unsigned h;
    int unsigned f;
    res = '{default: '0};
    h = block_edge() >> 1;
    x0 = longint'(regs_model.pad_size) + longint'(col) * longint'(h);
    y0 = longint'(regs_model.pad_size) + longint'(row) * longint'(h);
    vec_x_model = vx;
    vec_y_model = vy;
    sum_model = '0;
    pixels_model = 0;
    res.result_kind = RESULT_OFFSETS;
    t = x0 + y0 * longint'(regs_model.pitch_y);
    res.src_luma_offset = t[SRC_OFF_W-1:0];
    res.ref_luma_offset = displacement_of(vx, vy, longint'(regs_model.pitch_y),
                                          longint'(regs_model.img_pitch_y));
    if (regs_model.chroma_enable) begin
      cx = floor_steps(vx, 2, f);
      cy = floor_steps(vy, 2, f);
      t = (x0 >>> 1) + (y0 >>> 1) * longint'(regs_model.pitch_uv);
      res.src_chroma_offset = t[SRC_OFF_W-1:0];
      res.ref_chroma_offset = displacement_of(cx, cy, longint'(regs_model.pitch_uv),
                                              longint'(regs_model.img_pitch_uv));
    end
    res.mv_x = vx;
    res.mv_y = vy;
    engine_results_due = {engine_results_due, res};
  endfunction

  // Pixel request: add the absolute difference, close the block at its total
  function automatic void predict_accumulate(input logic [PIX_W-1:0] sp,
                                             input logic [PIX_W-1:0] rp);
    engine_result_t res;
    int unsigned d;
    int unsigned s;
    d = (sp >= rp) ? sp - rp : rp - sp;
    s = sum_model + d;
    sum_model = (s > SAD_MAX) ? SAD_MAX : SAD_W'(s);
    pixels_model++;
    if (pixels_model >= block_total()) begin
      res = '{default: '0};
      res.result_kind = RESULT_SAD;
      res.sad = sum_model;
      res.mv_x = vec_x_model;
      res.mv_y = vec_y_model;
      engine_results_due = {engine_results_due, res};
      sum_model = '0;
      pixels_model = 0;
    end
  endfunction

  // ---------------------------------------------------------------- random picks

  // Mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] edgy_value(input int unsigned bits);
    logic [31:0] mask;
    int unsigned r;
    mask = (32'd1 << bits) - 1;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return mask;
    return $urandom & mask;
  endfunction

  function automatic logic [PIX_W-1:0] rand_px();
    return PIX_W'(edgy_value(PIX_W));
  endfunction

  function automatic logic [IDX_W-1:0] rand_index();
    return IDX_W'(edgy_value(IDX_W));
  endfunction

  function automatic logic signed [VEC_W-1:0] rand_vec();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 4))
        0:       return 16'sh8000;
        1:       return 16'sh7FFF;
        2:       return -16'sd1;
        3:       return 16'sd1;
        default: return 16'sd0;
      endcase
    end
    if (r < 50) return VEC_W'(int'($urandom_range(0, 63)) - 32);
    return VEC_W'($urandom);
  endfunction

  // ---------------------------------------------------------------- drivers

  // Send one request; valid stays high for a back-to-back follower
  task automatic send_request(input logic kind,
                              input logic signed [VEC_W-1:0] vx,
                              input logic signed [VEC_W-1:0] vy,
                              input logic [IDX_W-1:0] col,
                              input logic [IDX_W-1:0] row,
                              input logic [PIX_W-1:0] sp,
                              input logic [PIX_W-1:0] rp);
    int unsigned gap;
    gap = pick_gap(send_idle);
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.kind      <= kind;
    item_ch.vec_x     <= vx;
    item_ch.vec_y     <= vy;
    item_ch.block_col <= col;
    item_ch.block_row <= row;
    item_ch.src_pixel <= sp;
    item_ch.ref_pixel <= rp;
    do @(posedge clk); while (!item_ch.ready);
    if (kind == KIND_BEGIN) begin
      predict_offsets(vx, vy, col, row);
    end else begin
      predict_accumulate(sp, rp);
    end
    requests_sent++;
  endtask

  // Pixel fields carry noise on begin requests and vice versa
  task automatic send_begin(input logic signed [VEC_W-1:0] vx,
                            input logic signed [VEC_W-1:0] vy,
                            input logic [IDX_W-1:0] col,
                            input logic [IDX_W-1:0] row);
    send_request(KIND_BEGIN, vx, vy, col, row, PIX_W'($urandom), PIX_W'($urandom));
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] sp, input logic [PIX_W-1:0] rp);
    send_request(KIND_PIXEL, VEC_W'($urandom), VEC_W'($urandom), IDX_W'($urandom),
                 IDX_W'($urandom), sp, rp);
  endtask

  task automatic send_random_pixels(input int unsigned count);
    repeat (count) send_pixel(rand_px(), rand_px());
  endtask

  // Drop valid, drain every expected result, let in-flight pixels retire
  task automatic settle_block();
    item_ch.valid <= 1'b0;
    while (engine_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write, only once the engine is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    settle_block();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_BLOCK_SIZE:    regs_model.block_size    = value[5:0];
      REG_NPEL_MODE:     regs_model.npel_mode     = value[2:0];
      REG_CHROMA_ENABLE: regs_model.chroma_enable = value[0];
      REG_PAD_SIZE:      regs_model.pad_size      = value[PAD_W-1:0];
      REG_PITCH_Y:       regs_model.pitch_y       = value[PITCH_W-1:0];
      REG_PITCH_UV:      regs_model.pitch_uv      = value[PITCH_W-1:0];
      REG_IMG_PITCH_Y:   regs_model.img_pitch_y   = value[IMG_W-1:0];
      REG_IMG_PITCH_UV:  regs_model.img_pitch_uv  = value[IMG_W-1:0];
      default: ;
    endcase
  endtask

  // Result side: ready with random stall runs, mostly short
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        result_ch.ready <= 1'b1;
        if (sink_stalls && $urandom_range(0, 3) == 0) begin
          stall_left = ($urandom_range(0, 99) < 75) ? $urandom_range(1, 3)
                                                    : $urandom_range(10, 40);
        end
      end
    end
  end

  // ---------------------------------------------------------------- checking

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each accepted result against the oldest expectation
  always @(posedge clk) begin
    engine_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (engine_results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d sad %0h",
                 $time, result_ch.result_kind, result_ch.sad);
        mismatches++;
      end else begin
        want = engine_results_due.pop_front();
        check_field("result_kind", want.result_kind, result_ch.result_kind);
        check_field("src_luma_offset", want.src_luma_offset, result_ch.src_luma_offset);
        check_field("ref_luma_offset", want.ref_luma_offset, result_ch.ref_luma_offset);
        check_field("src_chroma_offset", want.src_chroma_offset,
                    result_ch.src_chroma_offset);
        check_field("ref_chroma_offset", want.ref_chroma_offset,
                    result_ch.ref_chroma_offset);
        check_field("sad", want.sad, result_ch.sad);
        check_field("mv_x", want.mv_x, result_ch.mv_x);
        check_field("mv_y", want.mv_y, result_ch.mv_y);
      end
    end
  end

  // Abort when no request, result or register write moves for too long
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("motion_block_sad_engine_unit_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests

  // Pixels straight after reset use the zero vector, a block edge of 4 and default registers otherwise
  task automatic test_pixels_before_begin();
    write_reg(REG_BLOCK_SIZE, 4);
    send_pixel(8'd255, 8'd0);
    send_pixel(8'd0, 8'd255);
    send_pixel(8'd128, 8'd128);
    send_random_pixels(13);
  endtask

  // Extreme vectors and indexes under every sub-pel mode, with wrapping offsets
  task automatic test_begin_offsets();
    logic [2:0] modes [5];
    modes = '{NPEL_FULL, NPEL_HALF, 3'd4, 3'd0, 3'd7};
    write_reg(REG_PAD_SIZE, 255);
    write_reg(REG_PITCH_Y, 16'hFFFF);
    write_reg(REG_PITCH_UV, 16'hFFFF);
    write_reg(REG_IMG_PITCH_Y, 24'hFFFFFF);
    write_reg(REG_IMG_PITCH_UV, 24'hFFFFFF);
    write_reg(REG_CHROMA_ENABLE, 1);
    foreach (modes[m]) begin
      write_reg(REG_NPEL_MODE, modes[m]);
      send_begin(16'sh8000, 16'sh7FFF, 10'd1023, 10'd1023);
      send_begin(16'sh7FFF, 16'sh8000, 10'd0, 10'd0);
      send_begin(-16'sd5, 16'sd6, 10'd1023, 10'd1);
    end
    // chroma fields read zero when chroma is off
    write_reg(REG_CHROMA_ENABLE, 0);
    send_begin(-16'sd7, 16'sd9, 10'd3, 10'd4);
    write_reg(REG_PITCH_Y, 0);
    write_reg(REG_PAD_SIZE, 0);
    send_begin(16'sd13, -16'sd1, 10'd1023, 10'd1023);
  endtask

  // Whole blocks with and without chroma, and a block with no begin
  task automatic test_block_sums();
    write_reg(REG_PITCH_Y, 2048);
    write_reg(REG_PITCH_UV, 1024);
    write_reg(REG_NPEL_MODE, NPEL_HALF);
    write_reg(REG_CHROMA_ENABLE, 1);
    send_begin(16'sd5, -16'sd7, 10'd3, 10'd2);
    send_random_pixels(block_total());
    // vector is kept for the next block
    send_random_pixels(block_total());
    write_reg(REG_CHROMA_ENABLE, 0);
    write_reg(REG_BLOCK_SIZE, 6);
    send_begin(-16'sd3, 16'sd2, 10'd7, 10'd9);
    send_random_pixels(block_total());
  endtask

  // A begin in mid-block drops the partial sum
  task automatic test_restart_mid_block();
    write_reg(REG_BLOCK_SIZE, 4);
    send_begin(16'sd1, 16'sd1, 10'd1, 10'd1);
    send_random_pixels(10);
    send_begin(-16'sd2, 16'sd3, 10'd2, 10'd5);
    send_random_pixels(block_total());
  endtask

  // Out-of-range sizes clamp; a register change ends an open block early
  task automatic test_clamp_and_reconfig();
    write_reg(REG_BLOCK_SIZE, 2);
    send_begin(16'sd4, 16'sd4, 10'd5, 10'd6);
    send_random_pixels(block_total());
    write_reg(REG_BLOCK_SIZE, 63);
    send_begin(16'sd9, -16'sd9, 10'd1023, 10'd2);
    send_random_pixels(20);
    write_reg(REG_BLOCK_SIZE, 4);
    send_pixel(8'd17, 8'd3);
    write_reg(REG_CHROMA_ENABLE, 1);
    send_begin(16'sd2, 16'sd2, 10'd0, 10'd1);
    send_random_pixels(18);
    write_reg(REG_CHROMA_ENABLE, 0);
    send_pixel(8'd0, 8'd255);
  endtask

  // Largest edge with chroma at full difference, closed early by a smaller edge
  task automatic test_largest_block();
    write_reg(REG_BLOCK_SIZE, MAX_BLOCK_SIZE);
    write_reg(REG_CHROMA_ENABLE, 1);
    send_begin(16'sh7FFF, 16'sh8000, 10'd4, 10'd4);
    for (int k = 0; k < LARGEST_PIXELS; k++) begin
      if (k % 2 == 0) begin
        send_pixel(8'd255, 8'd0);
      end else begin
        send_pixel(8'd0, 8'd255);
      end
    end
    write_reg(REG_BLOCK_SIZE, 8);
    send_pixel(8'd255, 8'd0);
  endtask

  // Random register phases, each with well-formed, broken and stray sequences
  task automatic test_random_traffic();
    int unsigned start;
    int unsigned total;
    int unsigned npx;
    int unsigned r;
    logic [31:0] value;
    logic [31:0] mask;
    start = requests_sent;
    while (requests_sent - start < RANDOM_ITEMS) begin
      send_idle = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);
      foreach (ALL_REGS[i]) begin
        case (ALL_REGS[i])
          REG_BLOCK_SIZE: begin
            r = $urandom_range(0, 99);
            if (r < 45) value = 4;
            else if (r < 65) value = $urandom_range(5, 8);
            else if (r < 75) value = $urandom_range(0, 3);
            else if (r < 85) value = $urandom_range(9, 12);
            else if (r < 92) value = 16;
            else value = $urandom_range(33, 63);
            mask = 32'h3F;
          end
          REG_NPEL_MODE: begin
            value = $urandom_range(0, 7);
            mask = 32'h7;
          end
          REG_CHROMA_ENABLE: begin
            value = $urandom_range(0, 1);
            mask = 32'h1;
          end
          REG_PAD_SIZE: begin
            value = edgy_value(PAD_W);
            mask = 32'hFF;
          end
          REG_PITCH_Y, REG_PITCH_UV: begin
            value = edgy_value(PITCH_W);
            mask = 32'hFFFF;
          end
          default: begin
            value = edgy_value(IMG_W);
            mask = 32'hFFFFFF;
          end
        endcase
        // occasionally put noise above the register width
        if ($urandom_range(0, 7) == 0) value = value | ($urandom & ~mask);
        write_reg(ALL_REGS[i], CFG_DATA_W'(value));
      end
      total = block_total();
      repeat ($urandom_range(1, 4)) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          send_begin(rand_vec(), rand_vec(), rand_index(), rand_index());
          npx = (total <= LONG_BLOCK) ? total : $urandom_range(1, 40);
        end else if (r < 88) begin
          send_begin(rand_vec(), rand_vec(), rand_index(), rand_index());
          npx = $urandom_range(0, (total - 1 < 40) ? total - 1 : 40);
        end else begin
          npx = $urandom_range(1, (total <= LONG_BLOCK) ? total + 4 : 40);
        end
        send_random_pixels(npx);
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.kind = KIND_BEGIN;
    item_ch.vec_x = '0;
    item_ch.vec_y = '0;
    item_ch.block_col = '0;
    item_ch.block_row = '0;
    item_ch.src_pixel = '0;
    item_ch.ref_pixel = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_BLOCK_SIZE;
    cfg_ch.data = '0;
    regs_model = '{block_size: 6'd8, npel_mode: NPEL_FULL, chroma_enable: 1'b0,
                   pad_size: '0, pitch_y: 16'd2048, pitch_uv: 16'd1024,
                   img_pitch_y: '0, img_pitch_uv: '0};
    sum_model = '0;
    pixels_model = 0;
    vec_x_model = '0;
    vec_y_model = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_pixels_before_begin();
    test_begin_offsets();
    test_block_sums();
    test_restart_mid_block();
    test_clamp_and_reconfig();
    test_largest_block();
    test_random_traffic();

    // drain, then keep watching for stray results
    settle_block();
    if (mismatches == 0 && engine_results_due.size() == 0) begin
      $display("motion_block_sad_engine_unit_tb: PASS");
    end else begin
      $display("motion_block_sad_engine_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
src/mbs_pkg.sv
src/mbs_if.sv
src/mbs_front.sv
src/mbs_queue.sv
src/mbs_back.sv
src/motion_block_sad_engine_unit.sv
sim/motion_block_sad_engine_unit_tb.sv
